// ===== design/tpawr_pkg.sv =====
// package for the temporal pixel average block: payload structs, accumulator entry,
// function codes and the reciprocal table used by the rounding divider
// no dependencies
`timescale 1ns / 1ps

package tpawr_pkg;

    localparam int NEIGHBOURS_EACH_SIDE = 4;
    localparam int COUNT_LIMIT_INT      = 2 * NEIGHBOURS_EACH_SIDE + 1;
    localparam int COUNT_W              = $clog2(COUNT_LIMIT_INT + 1);
    localparam int SUM_W                = 8 + COUNT_W;
    localparam int INDEX_W              = 16;
    localparam int RECIP_SHIFT          = 16;
    localparam int RECIP_W              = RECIP_SHIFT + 1;
    localparam int PROD_W               = SUM_W + RECIP_W;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT     = COUNT_W'(COUNT_LIMIT_INT);
    localparam logic [7:0]         RESET_THRESHOLD = 8'd40;

    typedef enum logic [1:0] {
        FUNC_BEGIN  = 2'd0,
        FUNC_ADD    = 2'd1,
        FUNC_FINISH = 2'd2
    } func_t;

    typedef struct packed {
        logic [1:0]         func;
        logic [INDEX_W-1:0] pixel_index;
        logic [7:0]         ref_blue;
        logic [7:0]         ref_green;
        logic [7:0]         ref_red;
        logic [7:0]         cand_blue;
        logic [7:0]         cand_green;
        logic [7:0]         cand_red;
    } tpawr_in_t;

    typedef struct packed {
        logic [INDEX_W-1:0] out_index;
        logic [7:0]         out_blue;
        logic [7:0]         out_green;
        logic [7:0]         out_red;
    } tpawr_out_t;

    typedef struct packed {
        logic [SUM_W-1:0]   sum_blue;
        logic [SUM_W-1:0]   sum_green;
        logic [SUM_W-1:0]   sum_red;
        logic [COUNT_W-1:0] count;
    } acc_entry_t;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        acc_entry_t         entry;
    } div_req_t;

    // ceil(2^16 / count); exact floor for sums below 2^16 / 9
    function automatic logic [RECIP_W-1:0] recip(input logic [COUNT_W-1:0] count);
        logic [RECIP_W-1:0] r;
        unique case (count)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            4'd9:    r = 17'd7282;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/temporal_pixel_average_with_rejection_top.sv =====
// top level of the temporal pixel average block: accumulator memory with
// read-modify-write stage, threshold register, rounding divider for finish beats
// depends on tpawr_pkg and tpawr_rdiv
`timescale 1ns / 1ps

// Temporal pixel average with rejection. Each input beat carries a function code,
// a pixel index and a reference and candidate pixel. Begin seeds the accumulator
// entry of that pixel, add folds in the candidate when (|dB| + 2|dG| + |dR|) / 4
// is at most thr_reg and the entry holds fewer than nine pixels, finish
// emits the per-channel average rounded half to even. The block takes one beat
// per clock unless back-pressure holds it; the accumulator is a 65536 x 40
// single-port-write memory with a registered read, and back-to-back beats on the
// same pixel are forwarded, so they never stall. A finish result passes through
// the memory read on the accepting edge, then the reciprocal multiply, remainder
// correction and output registers; only m_ready back-pressure stops intake.
// Entries hold garbage until a begin writes them; there is no clearing pass
// after reset.
module temporal_pixel_average_with_rejection_top
    import tpawr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  tpawr_in_t  s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output tpawr_out_t m_data
);

    localparam int DEPTH = 2 ** INDEX_W;

    acc_entry_t acc_mem [DEPTH];

    logic [7:0] thr_reg;

    logic       s1_valid_reg;
    tpawr_in_t  s1_item_reg;
    acc_entry_t rd_data_reg;

    logic               fwd_valid_reg;
    logic [INDEX_W-1:0] fwd_index_reg;
    acc_entry_t         fwd_data_reg;

    logic       s1_load;
    logic       s1_leave;
    logic       s1_ready;
    logic       s1_finish;
    acc_entry_t cur_entry;
    acc_entry_t new_entry;
    logic       wr_en;
    logic       div_ready;
    div_req_t   div_req;

    logic [7:0] d_blue;
    logic [7:0] d_green;
    logic [7:0] d_red;
    logic [9:0] wdiff;
    logic [7:0] y;
    logic       take;

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    assign s1_finish = s1_valid_reg && (s1_item_reg.func == FUNC_FINISH);
    assign s1_ready  = !s1_finish || div_ready;
    assign s_ready   = s1_ready;
    assign s1_load   = s_valid && s_ready;
    assign s1_leave  = s1_valid_reg && s1_ready;

    // a write landing on the same edge as our read is missed by the memory
    assign cur_entry = (fwd_valid_reg && (fwd_index_reg == s1_item_reg.pixel_index))
                       ? fwd_data_reg : rd_data_reg;

    assign d_blue  = abs_diff(s1_item_reg.ref_blue, s1_item_reg.cand_blue);
    assign d_green = abs_diff(s1_item_reg.ref_green, s1_item_reg.cand_green);
    assign d_red   = abs_diff(s1_item_reg.ref_red, s1_item_reg.cand_red);
    assign wdiff   = {2'b00, d_blue} + {1'b0, d_green, 1'b0} + {2'b00, d_red};
    assign y       = wdiff[9:2];
    assign take    = (y <= thr_reg) && (cur_entry.count < COUNT_LIMIT);

    always_comb begin
        new_entry = cur_entry;
        wr_en     = 1'b0;
        priority if (s1_item_reg.func == FUNC_BEGIN) begin
            new_entry.sum_blue  = {{(SUM_W-8){1'b0}}, s1_item_reg.ref_blue};
            new_entry.sum_green = {{(SUM_W-8){1'b0}}, s1_item_reg.ref_green};
            new_entry.sum_red   = {{(SUM_W-8){1'b0}}, s1_item_reg.ref_red};
            new_entry.count     = COUNT_W'(1);
            wr_en               = s1_leave;
        end else if (s1_item_reg.func == FUNC_ADD) begin
            new_entry.sum_blue  = cur_entry.sum_blue
                                  + {{(SUM_W-8){1'b0}}, s1_item_reg.cand_blue};
            new_entry.sum_green = cur_entry.sum_green
                                  + {{(SUM_W-8){1'b0}}, s1_item_reg.cand_green};
            new_entry.sum_red   = cur_entry.sum_red
                                  + {{(SUM_W-8){1'b0}}, s1_item_reg.cand_red};
            new_entry.count     = cur_entry.count + COUNT_W'(1);
            wr_en               = s1_leave && take;
        end else begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            acc_mem[s1_item_reg.pixel_index] <= new_entry;
        end
        if (s1_load) begin
            rd_data_reg <= acc_mem[s_data.pixel_index];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg       <= RESET_THRESHOLD;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
            if (s1_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (s1_load) begin
                fwd_valid_reg <= wr_en;
            end else if (s1_leave) begin
                // stage empties, the next read already sees this write in memory
                fwd_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_load) begin
            s1_item_reg   <= s_data;
            fwd_index_reg <= s1_item_reg.pixel_index;
            fwd_data_reg  <= new_entry;
        end
    end

    assign div_req.index = s1_item_reg.pixel_index;
    assign div_req.entry = cur_entry;

    tpawr_rdiv u_rdiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s1_finish),
        .in_ready (div_ready),
        .in_req   (div_req),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ===== design/tpawr_rdiv.sv =====
// rounding divider pipeline: sum / count per channel, round half to even, saturate
// to 8 bits; reciprocal multiply, remainder correction, output register
// depends on tpawr_pkg
`timescale 1ns / 1ps

module tpawr_rdiv
    import tpawr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  div_req_t   in_req,
    output logic       m_valid,
    input  logic       m_ready,
    output tpawr_out_t m_data
);

    // multiply stage
    logic     mul_valid_reg;
    div_req_t mul_req_reg;
    logic     mul_ready;

    // correction stage
    logic               cor_valid_reg;
    div_req_t           cor_req_reg;
    logic [SUM_W-1:0]   cor_q_blue_reg;
    logic [SUM_W-1:0]   cor_q_green_reg;
    logic [SUM_W-1:0]   cor_q_red_reg;
    logic               cor_ready;

    logic       out_valid_reg;
    tpawr_out_t out_data_reg;
    tpawr_out_t out_data_next;
    logic       out_ready;

    logic [RECIP_W-1:0] rcp;
    logic [PROD_W-1:0]  prod_blue;
    logic [PROD_W-1:0]  prod_green;
    logic [PROD_W-1:0]  prod_red;

    function automatic logic [7:0] round_chan(input logic [SUM_W-1:0]   sum,
                                              input logic [SUM_W-1:0]   q,
                                              input logic [COUNT_W-1:0] count);
        logic [SUM_W+COUNT_W-1:0] qc;
        logic [SUM_W+COUNT_W-1:0] diff;
        logic [COUNT_W:0]         rem2;
        logic                     up;
        logic [SUM_W:0]           qr;
        logic [7:0]               res;
        qc   = q * count;
        diff = {{COUNT_W{1'b0}}, sum} - qc;
        rem2 = {diff[COUNT_W-1:0], 1'b0};
        up   = (rem2 > {1'b0, count}) || ((rem2 == {1'b0, count}) && q[0]);
        qr   = {1'b0, q} + {{SUM_W{1'b0}}, up};
        if (count == '0) begin
            res = 8'd0;
        end else if (qr > (SUM_W+1)'(255)) begin
            res = 8'd255;
        end else begin
            res = qr[7:0];
        end
        return res;
    endfunction

    assign out_ready = !out_valid_reg || m_ready;
    assign cor_ready = !cor_valid_reg || out_ready;
    assign mul_ready = !mul_valid_reg || cor_ready;
    assign in_ready  = mul_ready;

    assign rcp        = recip(mul_req_reg.entry.count);
    assign prod_blue  = mul_req_reg.entry.sum_blue * rcp;
    assign prod_green = mul_req_reg.entry.sum_green * rcp;
    assign prod_red   = mul_req_reg.entry.sum_red * rcp;

    always_comb begin
        out_data_next.out_index = cor_req_reg.index;
        out_data_next.out_blue  = round_chan(cor_req_reg.entry.sum_blue, cor_q_blue_reg,
                                             cor_req_reg.entry.count);
        out_data_next.out_green = round_chan(cor_req_reg.entry.sum_green, cor_q_green_reg,
                                             cor_req_reg.entry.count);
        out_data_next.out_red   = round_chan(cor_req_reg.entry.sum_red, cor_q_red_reg,
                                             cor_req_reg.entry.count);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            cor_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (mul_ready) begin
                mul_valid_reg <= in_valid;
            end
            if (cor_ready) begin
                cor_valid_reg <= mul_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= cor_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_ready && in_valid) begin
            mul_req_reg <= in_req;
        end
        if (cor_ready && mul_valid_reg) begin
            cor_req_reg     <= mul_req_reg;
            cor_q_blue_reg  <= prod_blue[RECIP_SHIFT +: SUM_W];
            cor_q_green_reg <= prod_green[RECIP_SHIFT +: SUM_W];
            cor_q_red_reg   <= prod_red[RECIP_SHIFT +: SUM_W];
        end
        if (out_ready && cor_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== bench/temporal_pixel_average_with_rejection_top_test.sv =====
// testbench for temporal_pixel_average_with_rejection_top: sends begin, add and finish beats,
// mirrors the accumulator memory to predict each rounded average and compares every output beat
// depends on tpawr_pkg and temporal_pixel_average_with_rejection_top
`timescale 1ns / 1ps

module temporal_pixel_average_with_rejection_top_test;
    import tpawr_pkg::*;

    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         DRAIN_CYCLES  = 8;
    localparam logic [1:0] FUNC_RESERVED = 2'd3;

    typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;
    typedef enum logic [1:0] {SEQ_SEED, SEQ_ACCUM, SEQ_EMIT, SEQ_DONE} seq_stage_e;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = '0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    tpawr_in_t  s_data      = '0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    tpawr_out_t m_data;

    // mirror of the accumulator memory and the threshold register
    acc_entry_t  accum [65536];
    bit          is_seeded [65536];
    logic [15:0] seeded_pixels [$];
    logic [7:0]  threshold_model = RESET_THRESHOLD;
    tpawr_out_t  expected_averages [$];

    int         error_count     = 0;
    int         cycle_count     = 0;
    int         burst_left      = 1;
    int         gap_max         = 0;
    logic       rx_always_ready = 1'b0;
    rx_mode_e   rx_mode         = RX_OPEN;
    int         rx_phase_left   = 0;
    tpawr_out_t beat_want;

    temporal_pixel_average_with_rejection_top u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[temporal_pixel_average_with_rejection_top] ERROR");
            $finish;
        end
    end

    // receiver back-pressure, switching between stall patterns of random length
    always @(posedge aclk) begin
        if (rx_phase_left == 0) begin
            rx_mode       = rx_mode_e'($urandom_range(0, 3));
            rx_phase_left = $urandom_range(16, 400);
        end else begin
            rx_phase_left--;
        end
        if (rx_always_ready) begin
            m_ready <= 1'b1;
        end else begin
            case (rx_mode)
                RX_OPEN:  m_ready <= 1'b1;
                RX_LIGHT: m_ready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY: m_ready <= ($urandom_range(0, 3) == 0);
                default:  m_ready <= (rx_phase_left % 5 == 0);
            endcase
        end
    end

    function automatic int unsigned channel_gap(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? int'(a - b) : int'(b - a);
    endfunction

    function automatic logic [7:0] rounded_mean(input int unsigned total, input int unsigned cnt);
        int unsigned q;
        int unsigned r;
        if (cnt == 0) return 8'd0;
        q = total / cnt;
        r = total % cnt;
        // exact halves go to the even quotient
        if (2 * r > cnt || (2 * r == cnt && q[0])) q++;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function automatic bit predict_pixel(input tpawr_in_t item, output tpawr_out_t average);
        acc_entry_t  entry;
        int unsigned weighted;
        average = '0;
        entry   = accum[item.pixel_index];
        case (item.func)
            FUNC_BEGIN: begin
                entry.sum_blue          = SUM_W'(item.ref_blue);
                entry.sum_green         = SUM_W'(item.ref_green);
                entry.sum_red           = SUM_W'(item.ref_red);
                entry.count             = COUNT_W'(1);
                accum[item.pixel_index] = entry;
            end
            FUNC_ADD: begin
                weighted = (channel_gap(item.ref_blue, item.cand_blue)
                            + 2 * channel_gap(item.ref_green, item.cand_green)
                            + channel_gap(item.ref_red, item.cand_red)) / 4;
                if (weighted <= threshold_model && entry.count < COUNT_LIMIT) begin
                    entry.sum_blue          += SUM_W'(item.cand_blue);
                    entry.sum_green         += SUM_W'(item.cand_green);
                    entry.sum_red           += SUM_W'(item.cand_red);
                    entry.count             += COUNT_W'(1);
                    accum[item.pixel_index] = entry;
                end
            end
            FUNC_FINISH: begin
                average.out_index = item.pixel_index;
                average.out_blue  = rounded_mean(entry.sum_blue, entry.count);
                average.out_green = rounded_mean(entry.sum_green, entry.count);
                average.out_red   = rounded_mean(entry.sum_red, entry.count);
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic logic [7:0] nudge(input logic [7:0] base, input int spread);
        int v;
        v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    // random reference pixel; the neighbour is a copy, a near miss or unrelated
    function automatic tpawr_in_t random_item(input logic [1:0] func, input logic [15:0] index);
        tpawr_in_t it;
        int        spread;
        it.func        = func;
        it.pixel_index = index;
        it.ref_blue    = 8'($urandom);
        it.ref_green   = 8'($urandom);
        it.ref_red     = 8'($urandom);
        spread         = 1 << $urandom_range(0, 7);
        case ($urandom_range(0, 5))
            0: begin
                it.cand_blue  = it.ref_blue;
                it.cand_green = it.ref_green;
                it.cand_red   = it.ref_red;
            end
            1, 2, 3: begin
                it.cand_blue  = nudge(it.ref_blue, spread);
                it.cand_green = nudge(it.ref_green, spread);
                it.cand_red   = nudge(it.ref_red, spread);
            end
            default: begin
                it.cand_blue  = 8'($urandom);
                it.cand_green = 8'($urandom);
                it.cand_red   = 8'($urandom);
            end
        endcase
        return it;
    endfunction

    task automatic send_pixel(input tpawr_in_t item);
        tpawr_out_t average;
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (predict_pixel(item, average)) expected_averages.push_back(average);
        if (item.func == FUNC_BEGIN && !is_seeded[item.pixel_index]) begin
            is_seeded[item.pixel_index] = 1'b1;
            seeded_pixels.push_back(item.pixel_index);
        end
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            if (gap_max > 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge aclk);
            end
        end
    endtask

    task automatic send_fields(input logic [1:0] func, input logic [15:0] index,
                               input logic [7:0] rb, input logic [7:0] rg, input logic [7:0] rr,
                               input logic [7:0] cb, input logic [7:0] cg, input logic [7:0] cr);
        tpawr_in_t item;
        item.func        = func;
        item.pixel_index = index;
        item.ref_blue    = rb;
        item.ref_green   = rg;
        item.ref_red     = rr;
        item.cand_blue   = cb;
        item.cand_green  = cg;
        item.cand_red    = cr;
        send_pixel(item);
    endtask

    // adds and begins give no output beat, so let the pipeline empty before going on
    task automatic drain_block();
        s_valid <= 1'b0;
        while (expected_averages.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_threshold(input logic [7:0] value);
        drain_block();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en       <= 1'b0;
        threshold_model = value;
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (expected_averages.size() == 0) begin
                $error("out_index: expected no beat, got %0d", m_data.out_index);
                error_count++;
            end else begin
                beat_want = expected_averages.pop_front();
                check_field("out_index", beat_want.out_index, m_data.out_index);
                check_field("out_blue", beat_want.out_blue, m_data.out_blue);
                check_field("out_green", beat_want.out_green, m_data.out_green);
                check_field("out_red", beat_want.out_red, m_data.out_red);
            end
        end
    end

    // interleaved begin / add / finish sequences on up to four pixels, plus stray beats
    task automatic run_frames(input int item_budget);
        logic [15:0] slot_index [4];
        int          adds_left [4];
        seq_stage_e  stage [4];
        int          active;
        int          live;
        int          pick;
        int          sent;
        sent = 0;
        while (sent < item_budget) begin
            active = $urandom_range(1, 4);
            live   = active;
            for (int s = 0; s < 4; s++) begin
                if (seeded_pixels.size() != 0 && $urandom_range(0, 7) == 0)
                    slot_index[s] = seeded_pixels[$urandom_range(0, seeded_pixels.size() - 1)];
                else
                    slot_index[s] = 16'($urandom);
                adds_left[s] = $urandom_range(0, 11);
                stage[s]     = (s < active) ? SEQ_SEED : SEQ_DONE;
            end
            while (live != 0) begin
                if (seeded_pixels.size() != 0 && $urandom_range(0, 19) == 0) begin
                    pick = $urandom_range(0, seeded_pixels.size() - 1);
                    case ($urandom_range(0, 2))
                        0: send_pixel(random_item(FUNC_FINISH, seeded_pixels[pick]));
                        1: send_pixel(random_item(FUNC_ADD, seeded_pixels[pick]));
                        default: send_pixel(random_item(FUNC_RESERVED, 16'($urandom)));
                    endcase
                end
                pick = $urandom_range(0, active - 1);
                while (stage[pick] == SEQ_DONE) pick = (pick + 1) % active;
                case (stage[pick])
                    SEQ_SEED: begin
                        send_pixel(random_item(FUNC_BEGIN, slot_index[pick]));
                        stage[pick] = (adds_left[pick] != 0) ? SEQ_ACCUM : SEQ_EMIT;
                    end
                    SEQ_ACCUM: begin
                        // now and then the entry is reseeded halfway
                        send_pixel(random_item(($urandom_range(0, 29) == 0) ? FUNC_BEGIN : FUNC_ADD,
                                               slot_index[pick]));
                        adds_left[pick]--;
                        if (adds_left[pick] == 0) stage[pick] = SEQ_EMIT;
                    end
                    default: begin
                        // a few sequences never get their finish
                        if ($urandom_range(0, 9) != 0)
                            send_pixel(random_item(FUNC_FINISH, slot_index[pick]));
                        stage[pick] = SEQ_DONE;
                        live--;
                    end
                endcase
                sent++;
            end
        end
    endtask

    task automatic test_directed_corners();
        gap_max = 0;
        send_fields(FUNC_BEGIN, 16'h0000, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff);
        send_fields(FUNC_FINISH, 16'h0000, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
        send_fields(FUNC_BEGIN, 16'hffff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00);
        send_fields(FUNC_ADD, 16'hffff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
        send_fields(FUNC_FINISH, 16'hffff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        // weighted difference right at the reset threshold, one above, and a floored one
        send_fields(FUNC_BEGIN, 16'h5a5a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_fields(FUNC_ADD, 16'h5a5a, 8'h00, 8'h00, 8'h00, 8'd160, 8'h00, 8'h00);
        send_fields(FUNC_ADD, 16'h5a5a, 8'h00, 8'h00, 8'h00, 8'h00, 8'd82, 8'h00);
        send_fields(FUNC_ADD, 16'h5a5a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd163);
        send_fields(FUNC_FINISH, 16'h5a5a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        // 1.5, 0.5 and 3.5 must round to 2, 0 and 4
        send_fields(FUNC_BEGIN, 16'h0001, 8'd1, 8'd0, 8'd3, 8'h00, 8'h00, 8'h00);
        send_fields(FUNC_ADD, 16'h0001, 8'd1, 8'd0, 8'd3, 8'd2, 8'd1, 8'd4);
        send_fields(FUNC_FINISH, 16'h0001, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        // unused code leaves the entry alone, and finish does not clear it
        send_fields(FUNC_RESERVED, 16'h0001, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00);
        send_fields(FUNC_FINISH, 16'h0001, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    endtask

    task automatic test_count_saturation();
        send_fields(FUNC_BEGIN, 16'h00a5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        // eight adds fill the entry, the ninth is dropped
        repeat (9) send_fields(FUNC_ADD, 16'h00a5, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
        send_fields(FUNC_FINISH, 16'h00a5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_threshold_extremes();
        gap_max = 4;
        set_threshold(8'd0);
        // weighted 3 floors to 0 and passes, weighted 4 does not
        send_fields(FUNC_BEGIN, 16'h1234, 8'd10, 8'd10, 8'd10, 8'h00, 8'h00, 8'h00);
        send_fields(FUNC_ADD, 16'h1234, 8'd10, 8'd10, 8'd10, 8'd11, 8'd11, 8'd10);
        send_fields(FUNC_ADD, 16'h1234, 8'd10, 8'd10, 8'd10, 8'd12, 8'd11, 8'd10);
        send_fields(FUNC_FINISH, 16'h1234, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        run_frames(150);
        set_threshold(8'd255);
        // largest possible difference still passes
        send_fields(FUNC_BEGIN, 16'h4321, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_fields(FUNC_ADD, 16'h4321, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff);
        send_fields(FUNC_FINISH, 16'h4321, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        run_frames(150);
    endtask

    task automatic test_random_frames();
        // back-to-back beats with an always-ready receiver
        gap_max = 0;
        rx_always_ready <= 1'b1;
        set_threshold(RESET_THRESHOLD);
        run_frames(250);
        rx_always_ready <= 1'b0;
        gap_max = 6;
        set_threshold(8'($urandom_range(1, 254)));
        run_frames(350);
        set_threshold(8'($urandom_range(1, 20)));
        run_frames(350);
        gap_max = 2;
        set_threshold(8'($urandom_range(100, 254)));
        run_frames(350);
        gap_max = 10;
        set_threshold(RESET_THRESHOLD);
        run_frames(350);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_corners();
        test_count_saturation();
        test_threshold_extremes();
        test_random_frames();
        drain_block();
        if (error_count == 0 && expected_averages.size() == 0) begin
            $display("[temporal_pixel_average_with_rejection_top] OK");
        end else begin
            $display("[temporal_pixel_average_with_rejection_top] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tpawr_pkg.sv
design/tpawr_rdiv.sv
design/temporal_pixel_average_with_rejection_top.sv
bench/temporal_pixel_average_with_rejection_top_test.sv
